// ===== rtl/iwak_pkg.sv =====
`default_nettype none
package iwak_pkg;

  localparam int DATA_W     = 32;
  localparam int SUM_W      = 40;
  localparam int WINDOW_DEF = 100;
  localparam int CFG_IDX_W  = 3;
  localparam int NOISE_W    = 31;
  localparam int DIV_W      = 33;
  localparam int DIV_CNT_W  = 6;

  localparam logic [2:0]           AVG_DIGITS = 3'd5;
  localparam logic [DIV_CNT_W-1:0] GAIN_QBITS = 6'd17;
  localparam logic [16:0]          K_ONE      = 17'd65536;

  localparam logic [15:0] SNAP_LIMIT [3] = '{16'd50, 16'd25, 16'd23};

  localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST = 31'd1180;
  localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 31'd35521;
  localparam logic [NOISE_W-1:0] GAIN_RST [3] = '{31'd5824682, 31'd14441808, 31'd11567976};
  localparam logic [DATA_W-1:0]  BIAS_RST [3] = '{32'd125339, 32'd651549, 32'd244351};

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_in_x;
    logic signed [DATA_W-1:0] acc_in_y;
    logic signed [DATA_W-1:0] acc_in_z;
    logic signed [DATA_W-1:0] rate_in_x;
    logic signed [DATA_W-1:0] rate_in_y;
    logic signed [DATA_W-1:0] rate_in_z;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] acc_out_x;
    logic signed [DATA_W-1:0] acc_out_y;
    logic signed [DATA_W-1:0] acc_out_z;
    logic signed [DATA_W-1:0] rate_out_x;
    logic signed [DATA_W-1:0] rate_out_y;
    logic signed [DATA_W-1:0] rate_out_z;
  } out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE,
    CFG_MEASURE_NOISE,
    CFG_GAIN_X,
    CFG_GAIN_Y,
    CFG_GAIN_Z,
    CFG_BIAS_X,
    CFG_BIAS_Y,
    CFG_BIAS_Z
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG_GO,
    S_AVG_WAIT,
    S_K_GO,
    S_K_WAIT,
    S_K_MUL,
    S_K_EST,
    S_K_SCALE,
    S_K_OUT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
    logic [DIV_W-1:0]     rem0;
    logic [DATA_W-1:0]    low;
    logic [DIV_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
    logic [DIV_W-1:0]  rem;
  } div_rsp_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic [DATA_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/iwak_ram.sv =====
`default_nettype none
module iwak_ram #(
  parameter int DEPTH = iwak_pkg::WINDOW_DEF,
  parameter int WIDTH = 6 * iwak_pkg::DATA_W,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/iwak_div.sv =====
`default_nettype none
module iwak_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iwak_pkg::div_req_t req,
  output iwak_pkg::div_rsp_t      rsp
);

  logic                           busy;
  logic [iwak_pkg::DIV_CNT_W-1:0] cnt;
  logic [iwak_pkg::DIV_W-1:0]     rem;
  logic [iwak_pkg::DIV_W-1:0]     divisor;
  logic [iwak_pkg::DATA_W-1:0]    low;
  logic [iwak_pkg::DATA_W-1:0]    quot;
  logic                           done;
  logic [iwak_pkg::DIV_W:0]       trial;
  logic                           take;

  assign trial = {rem, low[iwak_pkg::DATA_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem0;
      low     <= req.low;
      divisor <= req.divisor;
      quot    <= '0;
    end else if (busy) begin
      rem  <= take ? iwak_pkg::DIV_W'(trial - {1'b0, divisor})
                   : trial[iwak_pkg::DIV_W-1:0];
      low  <= {low[iwak_pkg::DATA_W-2:0], 1'b0};
      quot <= {quot[iwak_pkg::DATA_W-2:0], take};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;
  assign rsp.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/imu_window_average_kalman.sv =====
// Channel   Signals                           Direction  Contents
// in        in_valid, in_ready, in_data       input      one six-axis sample
// out       out_valid, out_ready, out_data    output     conditioned sample
// cfg       cfg_we, cfg_index, cfg_data       input      noise, gain and bias writes
//
// One sample runs from one accepted transaction to the next through the window update,
// the six window averages (a constant divider that resolves eight quotient bits a cycle),
// the three Kalman axes, each paced by the shared gain divider that resolves one of 17
// quotient bits a cycle, then the load of the output register and a return to idle.
// A new transaction is accepted once the previous sample has reached the output
// register, even if that result is still unread.
// No clearing pass follows reset: until the window has wrapped, old samples read
// as zero. A stalled output only holds the finished sample back in its last state.
`default_nettype none
module imu_window_average_kalman #(
  parameter int WINDOW = iwak_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire iwak_pkg::in_t                  in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output iwak_pkg::out_t                      out_data,
  input  wire logic                           cfg_we,
  input  wire logic [iwak_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [iwak_pkg::DATA_W-1:0]    cfg_data
);

  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int ROW_W = 6 * iwak_pkg::DATA_W;
  localparam logic [24:0] AVG_RECIP   = 25'(((1 << 24) + WINDOW - 1) / WINDOW);
  localparam logic [15:0] AVG_DIVISOR = 16'(WINDOW);

  iwak_pkg::state_t state, state_next;

  logic [iwak_pkg::NOISE_W-1:0] process_noise, measure_noise;
  logic [iwak_pkg::NOISE_W-1:0] gain [3];
  logic signed [31:0]           bias [3];

  logic [PTR_W-1:0]                 ptr;
  logic                             full;
  logic [2:0]                       ch;
  logic signed [iwak_pkg::SUM_W-1:0] sums [6];
  logic signed [31:0]               est [3];
  logic [31:0]                      vari [3];
  logic signed [31:0]               snap [3];

  iwak_pkg::in_t     in_reg;
  iwak_pkg::in_t     old_row;
  logic [ROW_W-1:0]  rdata;
  logic signed [31:0] new_s [6];
  logic signed [31:0] old_s [6];
  logic               accept;

  iwak_pkg::div_req_t div_req;
  iwak_pkg::div_rsp_t div_rsp;

  logic [iwak_pkg::SUM_W-1:0] avg_src;
  logic [7:0]                 avg_rem;
  logic [31:0]                avg_quot;
  logic [2:0]                 avg_cnt;
  logic                       avg_done;
  logic [15:0]                avg_x;
  logic [40:0]                avg_prod;
  logic [7:0]                 avg_digit;
  logic [15:0]                avg_back;

  logic signed [31:0] avg [3];
  logic [31:0]        p1;
  logic               den_zero;
  logic [16:0]        k;
  logic signed [50:0] prod1;
  logic [48:0]        prod2;
  logic signed [32:0] diff;
  logic signed [63:0] prod3;
  logic [31:0]        acc_res [3];
  logic [31:0]        rate_res [3];

  logic signed [iwak_pkg::SUM_W-1:0] cur_sum;
  logic                              neg;
  logic [iwak_pkg::SUM_W-1:0]        mag;
  logic [31:0]                       a_val;
  logic [1:0]                        ridx;
  logic                              exact;
  logic signed [31:0]                snap_new;
  logic [32:0]                       p1_sum;
  logic [31:0]                       p1_c;
  logic [32:0]                       den_c;
  logic signed [32:0]                err;
  logic signed [50:0]                xsum;
  logic signed [31:0]                x_new;

  assign accept  = in_valid && in_ready;
  assign old_row = iwak_pkg::in_t'(rdata);

  assign new_s[0] = in_reg.acc_in_x;
  assign new_s[1] = in_reg.acc_in_y;
  assign new_s[2] = in_reg.acc_in_z;
  assign new_s[3] = in_reg.rate_in_x;
  assign new_s[4] = in_reg.rate_in_y;
  assign new_s[5] = in_reg.rate_in_z;
  assign old_s[0] = old_row.acc_in_x;
  assign old_s[1] = old_row.acc_in_y;
  assign old_s[2] = old_row.acc_in_z;
  assign old_s[3] = old_row.rate_in_x;
  assign old_s[4] = old_row.rate_in_y;
  assign old_s[5] = old_row.rate_in_z;

  iwak_ram #(
    .DEPTH(WINDOW),
    .WIDTH(ROW_W)
  ) u_ram (
    .clk  (clk),
    .we   (state == iwak_pkg::S_SUM),
    .waddr(ptr),
    .wdata(ROW_W'(in_reg)),
    .re   (accept),
    .raddr(ptr),
    .rdata(rdata)
  );

  iwak_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign cur_sum  = sums[ch];
  assign neg      = cur_sum[iwak_pkg::SUM_W-1];
  assign mag      = neg ? iwak_pkg::SUM_W'(-cur_sum) : iwak_pkg::SUM_W'(cur_sum);

  assign avg_x     = {avg_rem, avg_src[iwak_pkg::SUM_W-1 -: 8]};
  assign avg_prod  = 41'(avg_x) * 41'(AVG_RECIP);
  assign avg_digit = avg_prod[31:24];
  assign avg_back  = avg_x - (16'(avg_digit) * AVG_DIVISOR);
  assign avg_done  = (state == iwak_pkg::S_AVG_WAIT) && (avg_cnt == '0);

  assign a_val    = neg ? (~avg_quot + 32'd1) : avg_quot;
  assign ridx     = 2'(ch - 3'd3);
  assign exact    = (avg_rem == '0) && (avg_quot[15:0] == 16'd0)
                    && (avg_quot[31:16] < iwak_pkg::SNAP_LIMIT[ridx]);
  assign snap_new = exact ? $signed(a_val) : snap[ridx];

  assign p1_sum = {1'b0, vari[ch[1:0]]} + {2'b0, process_noise};
  assign p1_c   = p1_sum[32] ? 32'hFFFF_FFFF : p1_sum[31:0];
  assign den_c  = {1'b0, p1_c} + {2'b0, measure_noise};
  assign err    = 33'(avg[ch[1:0]]) - 33'(est[ch[1:0]]);
  assign xsum   = 51'(est[ch[1:0]]) + (prod1 >>> 16);
  assign x_new  = xsum[31:0];

  always_comb begin
    div_req.start   = (state == iwak_pkg::S_K_GO);
    div_req.count   = iwak_pkg::GAIN_QBITS;
    div_req.rem0    = iwak_pkg::DIV_W'(p1_c[31:1]);
    div_req.low     = {p1_c[0], 31'd0};
    div_req.divisor = den_c;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      iwak_pkg::S_IDLE:     if (accept) state_next = iwak_pkg::S_SUM;
      iwak_pkg::S_SUM:      state_next = iwak_pkg::S_AVG_GO;
      iwak_pkg::S_AVG_GO:   state_next = iwak_pkg::S_AVG_WAIT;
      iwak_pkg::S_AVG_WAIT: begin
        if (avg_done) begin
          state_next = (ch == 3'd5) ? iwak_pkg::S_K_GO : iwak_pkg::S_AVG_GO;
        end
      end
      iwak_pkg::S_K_GO:     state_next = iwak_pkg::S_K_WAIT;
      iwak_pkg::S_K_WAIT:   if (div_rsp.done) state_next = iwak_pkg::S_K_MUL;
      iwak_pkg::S_K_MUL:    state_next = iwak_pkg::S_K_EST;
      iwak_pkg::S_K_EST:    state_next = iwak_pkg::S_K_SCALE;
      iwak_pkg::S_K_SCALE:  state_next = iwak_pkg::S_K_OUT;
      iwak_pkg::S_K_OUT: begin
        state_next = (ch == 3'd2) ? iwak_pkg::S_DONE : iwak_pkg::S_K_GO;
      end
      iwak_pkg::S_DONE:     if (!out_valid || out_ready) state_next = iwak_pkg::S_IDLE;
      default:              state_next = iwak_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == iwak_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= iwak_pkg::S_IDLE;
      process_noise <= iwak_pkg::PROCESS_NOISE_RST;
      measure_noise <= iwak_pkg::MEASURE_NOISE_RST;
      for (int i = 0; i < 3; i++) begin
        gain[i] <= iwak_pkg::GAIN_RST[i];
        bias[i] <= iwak_pkg::BIAS_RST[i];
        est[i]  <= '0;
        vari[i] <= '0;
        snap[i] <= '0;
      end
      for (int i = 0; i < 6; i++) begin
        sums[i] <= '0;
      end
      ptr       <= '0;
      full      <= 1'b0;
      ch        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (iwak_pkg::cfg_idx_t'(cfg_index))
          iwak_pkg::CFG_PROCESS_NOISE: process_noise <= cfg_data[iwak_pkg::NOISE_W-1:0];
          iwak_pkg::CFG_MEASURE_NOISE: measure_noise <= cfg_data[iwak_pkg::NOISE_W-1:0];
          iwak_pkg::CFG_GAIN_X:        gain[0] <= cfg_data[iwak_pkg::NOISE_W-1:0];
          iwak_pkg::CFG_GAIN_Y:        gain[1] <= cfg_data[iwak_pkg::NOISE_W-1:0];
          iwak_pkg::CFG_GAIN_Z:        gain[2] <= cfg_data[iwak_pkg::NOISE_W-1:0];
          iwak_pkg::CFG_BIAS_X:        bias[0] <= cfg_data;
          iwak_pkg::CFG_BIAS_Y:        bias[1] <= cfg_data;
          iwak_pkg::CFG_BIAS_Z:        bias[2] <= cfg_data;
          default: ;
        endcase
      end
      if ((state == iwak_pkg::S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        iwak_pkg::S_SUM: begin
          for (int i = 0; i < 6; i++) begin
            sums[i] <= sums[i] + iwak_pkg::SUM_W'(new_s[i])
                       - (full ? iwak_pkg::SUM_W'(old_s[i]) : '0);
          end
          if (ptr == PTR_W'(WINDOW - 1)) begin
            ptr  <= '0;
            full <= 1'b1;
          end else begin
            ptr <= ptr + 1'b1;
          end
          ch <= '0;
        end
        iwak_pkg::S_AVG_WAIT: begin
          if (avg_done) begin
            if (ch >= 3'd3) begin
              snap[ridx] <= snap_new;
            end
            ch <= (ch == 3'd5) ? 3'd0 : ch + 3'd1;
          end
        end
        iwak_pkg::S_K_EST: begin
          est[ch[1:0]]  <= x_new;
          vari[ch[1:0]] <= prod2[47:16];
        end
        iwak_pkg::S_K_OUT: begin
          ch <= ch + 3'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= in_data;
    end
    case (state)
      iwak_pkg::S_AVG_GO: begin
        avg_src  <= mag;
        avg_rem  <= '0;
        avg_quot <= '0;
        avg_cnt  <= iwak_pkg::AVG_DIGITS;
      end
      iwak_pkg::S_AVG_WAIT: begin
        if (avg_done) begin
          if (ch < 3'd3) begin
            avg[ch[1:0]] <= $signed(a_val);
          end else begin
            rate_res[ridx] <= iwak_pkg::sat32(64'($signed(a_val)) - 64'(snap_new));
          end
        end else begin
          avg_src  <= {avg_src[iwak_pkg::SUM_W-9:0], 8'd0};
          avg_rem  <= avg_back[7:0];
          avg_quot <= {avg_quot[23:0], avg_digit};
          avg_cnt  <= avg_cnt - 3'd1;
        end
      end
      iwak_pkg::S_K_GO: begin
        p1       <= p1_c;
        den_zero <= (den_c == '0);
      end
      iwak_pkg::S_K_WAIT: begin
        if (den_zero) begin
          k <= '0;
        end else if (div_rsp.quot > 32'(iwak_pkg::K_ONE)) begin
          k <= iwak_pkg::K_ONE;
        end else begin
          k <= div_rsp.quot[16:0];
        end
      end
      iwak_pkg::S_K_MUL: begin
        prod1 <= 51'($signed({1'b0, k})) * 51'(err);
        prod2 <= 49'(iwak_pkg::K_ONE - k) * 49'(p1);
      end
      iwak_pkg::S_K_EST: begin
        diff <= 33'(x_new) - 33'(bias[ch[1:0]]);
      end
      iwak_pkg::S_K_SCALE: begin
        prod3 <= 64'(diff) * 64'($signed({1'b0, gain[ch[1:0]]}));
      end
      iwak_pkg::S_K_OUT: begin
        acc_res[ch[1:0]] <= iwak_pkg::sat32(prod3 >>> 16);
      end
      iwak_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.acc_out_x  <= acc_res[0];
          out_data.acc_out_y  <= acc_res[1];
          out_data.acc_out_z  <= acc_res[2];
          out_data.rate_out_x <= rate_res[0];
          out_data.rate_out_y <= rate_res[1];
          out_data.rate_out_z <= rate_res[2];
        end
      end
      default: ;
    endcase
  end

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == iwak_pkg::S_AVG_WAIT) || (state == iwak_pkg::S_K_WAIT))
    else $error("divider finished outside a wait state");

  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    full |=> full)
    else $error("window fill flag dropped");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == iwak_pkg::S_K_MUL) |-> (k <= iwak_pkg::K_ONE))
    else $error("Kalman gain above one");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == iwak_pkg::S_SUM))
    else $error("accepted sample did not start the window update");

endmodule
`default_nettype wire
